// ===== src/pgrepl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgrepl_pkg
// Shared types and constants for the FIFO/LRU page replacement unit.
// ----------------------------------------------------------------------------
package pgrepl_pkg;

  // field widths
  localparam int PAGE_W    = 32;
  localparam int TOTAL_W   = 48;
  localparam int LIMIT_W   = 11;
  localparam int CFG_IDX_W = 1;

  // saturation value of the running totals
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(128);
  localparam logic               MODE_RESET  = 1'b0;

  // replacement policies
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = CFG_IDX_W'(1);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp;        // compare the held page against the slot
    logic shift_all;  // eviction: every cell takes its upper neighbor
    logic shift_pref; // lru hit: cells at or above the hit take their neighbor
    logic load_en;    // the cell at the load index takes the page
  } cell_ctrl_t;

endpackage

// ===== src/pgrepl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgrepl_cell
// One slot of the replacement order: holds a page, compares it against the
// referenced page and shifts toward the oldest end on reorder or eviction.
// ----------------------------------------------------------------------------
module pgrepl_cell #(
  parameter int IDX   = 0,
  parameter int OCC_W = 11
) (
  input  logic                          clk,
  input  pgrepl_pkg::cell_ctrl_t        ctrl,
  input  logic [pgrepl_pkg::PAGE_W-1:0] page,
  input  logic [OCC_W-1:0]              occ,
  input  logic [OCC_W-1:0]              load_idx,
  input  logic                          pref,
  input  logic [pgrepl_pkg::PAGE_W-1:0] next_slot,
  output logic [pgrepl_pkg::PAGE_W-1:0] slot,
  output logic                          match
);

  localparam logic [OCC_W-1:0] IDX_V = OCC_W'(IDX);

  logic [pgrepl_pkg::PAGE_W-1:0] slot_r;
  logic                          match_r;
  logic                          load;
  logic                          shift;

  // slot update selects
  assign load  = ctrl.load_en && (IDX_V == load_idx);
  assign shift = ctrl.shift_all || (ctrl.shift_pref && pref);

  // compare only occupied slots
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      match_r <= (slot_r == page) && (IDX_V < occ);
    end
  end

  // slot register
  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= page;
    end else if (shift) begin
      slot_r <= next_slot;
    end
  end

  assign slot  = slot_r;
  assign match = match_r;

endmodule

// ===== src/pgrepl_prefix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgrepl_prefix
// Parallel prefix OR over the cell match flags: bit i is set when some cell
// at or below i matched. The top bit is the hit flag.
// ----------------------------------------------------------------------------
module pgrepl_prefix #(
  parameter int N = 1024
) (
  input  logic [N-1:0] match,
  output logic [N-1:0] pref
);

  localparam int LVLS = $clog2(N);

  logic [N-1:0] lvl [LVLS+1];

  assign lvl[0] = match;

  // log-depth doubling network
  for (genvar l = 0; l < LVLS; l++) begin : g_lvl
    localparam int DIST = 1 << l;
    for (genvar b = 0; b < N; b++) begin : g_bit
      if (b >= DIST) begin : g_or
        assign lvl[l+1][b] = lvl[l][b] | lvl[l][b-DIST];
      end else begin : g_pass
        assign lvl[l+1][b] = lvl[l][b];
      end
    end
  end

  assign pref = lvl[LVLS];

endmodule

// ===== src/page_replacement_fifo_lru.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru
// Fully associative page replacement unit with FIFO or LRU policy, built as
// a chain of slot cells ordered from oldest to newest.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel: one page number word per reference (valid/stall).
//   out_* channel: one result word per reference: hit flag, evicted page and
//   saturating hit and miss totals including that reference.
//   cfg_* port: replace_mode (index 0) and frame_limit (index 1); write only
//   while no reference is in flight.
// Sequence: the accepted word is held; all cells compare it in the compare
//   state; the update state resolves the hit, shifts and registers a result.
// Overlap: the next word is accepted in the update of the previous one; its
//   compare needs the slot contents written by that update.
// Stall: a finished result waits in the output register; the update of the
//   next reference holds until that register is free, and the input is
//   stalled meanwhile.
// Reset: no frames occupied, totals zero, FIFO mode, frame limit 128. Slot
//   contents are not cleared; only occupied slots are ever compared.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [pgrepl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pgrepl_pkg::LIMIT_W-1:0]     cfg_wr_data,
  // input words
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pgrepl_pkg::PAGE_W-1:0]      in_page_number,
  // result words
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_hit,
  output logic                               out_evicted_valid,
  output logic [pgrepl_pkg::PAGE_W-1:0]      out_evicted_page,
  output logic [pgrepl_pkg::TOTAL_W-1:0]     out_hit_count,
  output logic [pgrepl_pkg::TOTAL_W-1:0]     out_miss_count
);

  localparam int OCC_W = $clog2(MAX_FRAMES + 1);
  localparam int LW    = (OCC_W > pgrepl_pkg::LIMIT_W) ? OCC_W : pgrepl_pkg::LIMIT_W;
  localparam logic [LW-1:0] MAX_V = LW'(MAX_FRAMES);
  localparam logic [LW-1:0] ONE_V = LW'(1);

  pgrepl_pkg::state_t state_r, state_nxt;

  logic                           mode_r;
  logic [pgrepl_pkg::LIMIT_W-1:0] limit_r;
  logic [pgrepl_pkg::PAGE_W-1:0]  page_r;
  logic [OCC_W-1:0]               occ_r, occ_nxt;
  logic [pgrepl_pkg::TOTAL_W-1:0] hit_total_r, hit_total_nxt;
  logic [pgrepl_pkg::TOTAL_W-1:0] miss_total_r, miss_total_nxt;

  logic                           out_valid_r;
  logic                           out_hit_r;
  logic                           out_ev_valid_r;
  logic [pgrepl_pkg::PAGE_W-1:0]  out_ev_page_r;
  logic [pgrepl_pkg::TOTAL_W-1:0] out_hit_cnt_r;
  logic [pgrepl_pkg::TOTAL_W-1:0] out_miss_cnt_r;

  logic                           in_accept;
  logic                           upd_go;
  logic                           hit;
  logic                           full;
  logic [LW-1:0]                  lim_ext;
  logic [LW-1:0]                  eff_lim;
  logic [OCC_W-1:0]               load_idx;
  pgrepl_pkg::cell_ctrl_t         ctrl;

  logic [pgrepl_pkg::PAGE_W-1:0]  slot_w [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]          match_w;
  logic [MAX_FRAMES-1:0]          pref_w;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pgrepl_pkg::MODE_RESET;
      limit_r <= pgrepl_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pgrepl_pkg::CFG_REPLACE_MODE: mode_r  <= cfg_wr_data[0];
        pgrepl_pkg::CFG_FRAME_LIMIT:  limit_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // effective limit clamped to 1..MAX_FRAMES
  always_comb begin
    lim_ext = LW'(limit_r);
    if (lim_ext == '0) begin
      eff_lim = ONE_V;
    end else if (lim_ext > MAX_V) begin
      eff_lim = MAX_V;
    end else begin
      eff_lim = lim_ext;
    end
  end

  // hit resolution and update decision
  assign hit  = pref_w[MAX_FRAMES-1];
  assign full = (LW'(occ_r) >= eff_lim) && (occ_r != '0);

  always_comb begin
    load_idx = occ_r - OCC_W'(1);
    occ_nxt  = occ_r;
    if (!hit && !full) begin
      load_idx = occ_r;
      occ_nxt  = occ_r + OCC_W'(1);
    end
  end

  always_comb begin
    hit_total_nxt  = hit_total_r;
    miss_total_nxt = miss_total_r;
    if (hit) begin
      if (hit_total_r != pgrepl_pkg::TOTAL_MAX) begin
        hit_total_nxt = hit_total_r + pgrepl_pkg::TOTAL_W'(1);
      end
    end else if (miss_total_r != pgrepl_pkg::TOTAL_MAX) begin
      miss_total_nxt = miss_total_r + pgrepl_pkg::TOTAL_W'(1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgrepl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    upd_go         = 1'b0;
    in_stall       = 1'b1;
    ctrl           = '0;
    unique case (state_r)
      pgrepl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = pgrepl_pkg::ST_CMP;
        end
      end
      pgrepl_pkg::ST_CMP: begin
        ctrl.cmp  = 1'b1;
        state_nxt = pgrepl_pkg::ST_UPD;
      end
      pgrepl_pkg::ST_UPD: begin
        if (!out_valid_r || !out_stall) begin
          upd_go          = 1'b1;
          in_stall        = 1'b0;
          ctrl.shift_all  = !hit && full;
          ctrl.shift_pref = hit && (mode_r == pgrepl_pkg::MODE_LRU);
          ctrl.load_en    = !hit || (mode_r == pgrepl_pkg::MODE_LRU);
          state_nxt       = in_valid ? pgrepl_pkg::ST_CMP : pgrepl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pgrepl_pkg::ST_IDLE;
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  // held reference page
  always_ff @(posedge clk) begin
    if (in_accept) begin
      page_r <= in_page_number;
    end
  end

  // occupancy and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r        <= '0;
      hit_total_r  <= '0;
      miss_total_r <= '0;
    end else if (upd_go) begin
      occ_r        <= occ_nxt;
      hit_total_r  <= hit_total_nxt;
      miss_total_r <= miss_total_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_hit_r      <= hit;
      out_ev_valid_r <= ctrl.shift_all;
      out_ev_page_r  <= ctrl.shift_all ? slot_w[0] : '0;
      out_hit_cnt_r  <= hit_total_nxt;
      out_miss_cnt_r <= miss_total_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_hit_count     = out_hit_cnt_r;
  assign out_miss_count    = out_miss_cnt_r;

  // chain of slot cells, oldest at index 0
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic [pgrepl_pkg::PAGE_W-1:0] next_slot;
    if (i == MAX_FRAMES - 1) begin : g_last
      assign next_slot = '0;
    end else begin : g_mid
      assign next_slot = slot_w[i+1];
    end

    pgrepl_cell #(
      .IDX   (i),
      .OCC_W (OCC_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .page      (page_r),
      .occ       (occ_r),
      .load_idx  (load_idx),
      .pref      (pref_w[i]),
      .next_slot (next_slot),
      .slot      (slot_w[i]),
      .match     (match_w[i])
    );
  end

  // hit position prefix across the chain
  pgrepl_prefix #(
    .N (MAX_FRAMES)
  ) u_prefix (
    .match (match_w),
    .pref  (pref_w)
  );

endmodule
